[rtl/tlv8_pkg.sv]
// ----------------------------------------------------------------------------
// tlv8_pkg
// shared types and codes for the tlv8 stream parser
// ----------------------------------------------------------------------------
package tlv8_pkg;

  // parser phase codes
  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  // classification of one stream byte
  typedef enum logic [1:0] {
    KIND_TAG = 2'd0,
    KIND_LEN = 2'd1,
    KIND_PAY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       fresh_list;
    logic       chunk_last;
  } item_t;

  typedef struct packed {
    kind_e       byte_kind;
    logic [7:0]  record_tag;
    logic [7:0]  payload_byte;
    logic        new_record;
    logic [15:0] payload_offset;
    logic        fragment_done;
    logic [1:0]  phase_after;
    logic        chunk_end;
  } result_t;

endpackage

[rtl/tlv8_in_if.sv]
// ----------------------------------------------------------------------------
// tlv8_in_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface tlv8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       fresh_list;
  logic       chunk_last;

  modport source (output valid, output data_byte, output fresh_list, output chunk_last,
                  input ready);
  modport sink   (input valid, input data_byte, input fresh_list, input chunk_last,
                  output ready);
endinterface

[rtl/tlv8_out_if.sv]
// ----------------------------------------------------------------------------
// tlv8_out_if
// per-byte decode result channel out of the parser
// ----------------------------------------------------------------------------
interface tlv8_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic [7:0]  record_tag;
  logic [7:0]  payload_byte;
  logic        new_record;
  logic [15:0] payload_offset;
  logic        fragment_done;
  logic [1:0]  phase_after;
  logic        chunk_end;

  modport source (output valid, output byte_kind, output record_tag, output payload_byte,
                  output new_record, output payload_offset, output fragment_done,
                  output phase_after, output chunk_end, input ready);
  modport sink   (input valid, input byte_kind, input record_tag, input payload_byte,
                  input new_record, input payload_offset, input fragment_done,
                  input phase_after, input chunk_end, output ready);
endinterface

[rtl/tlv8_decode.sv]
// ----------------------------------------------------------------------------
// tlv8_decode
// phase tracker and per-byte classification, state updated on each advance
// ----------------------------------------------------------------------------
module tlv8_decode #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  tlv8_pkg::item_t   item_i,
  output tlv8_pkg::result_t res_o
);

  logic [1:0]              phase_q, phase_d;
  logic [7:0]              tag_q, tag_d;
  logic                    have_q, have_d;
  logic [7:0]              left_q, left_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;

  // state as seen by this byte, after an optional list restart
  logic [1:0]              ph_eff;
  logic [7:0]              tag_eff;
  logic                    have_eff;
  logic [7:0]              left_eff;
  logic [OFFSET_WIDTH-1:0] offset_eff;
  logic [15:0]             offset_clamped;
  logic [7:0]              left_dec;

  assign ph_eff     = item_i.fresh_list ? tlv8_pkg::PH_TAG : phase_q;
  assign tag_eff    = item_i.fresh_list ? 8'd0 : tag_q;
  assign have_eff   = item_i.fresh_list ? 1'b0 : have_q;
  assign left_eff   = item_i.fresh_list ? 8'd0 : left_q;
  assign offset_eff = item_i.fresh_list ? '0 : offset_q;
  assign left_dec   = left_eff - 8'd1;

  generate
    if (OFFSET_WIDTH > 16) begin : g_clamp
      assign offset_clamped = (|offset_eff[OFFSET_WIDTH-1:16]) ? 16'hFFFF
                                                               : offset_eff[15:0];
    end else begin : g_extend
      assign offset_clamped = 16'(offset_eff);
    end
  endgenerate

  always_comb begin
    phase_d  = ph_eff;
    tag_d    = tag_eff;
    have_d   = have_eff;
    left_d   = left_eff;
    offset_d = offset_eff;

    res_o                = '0;
    res_o.byte_kind      = tlv8_pkg::KIND_TAG;
    res_o.chunk_end      = item_i.chunk_last;

    case (ph_eff)
      tlv8_pkg::PH_LEN: begin
        res_o.byte_kind  = tlv8_pkg::KIND_LEN;
        res_o.record_tag = tag_eff;
        left_d           = item_i.data_byte;
        if (item_i.data_byte == 8'd0) begin
          res_o.fragment_done = 1'b1;
          phase_d             = tlv8_pkg::PH_TAG;
        end else begin
          phase_d = tlv8_pkg::PH_PAY;
        end
      end
      tlv8_pkg::PH_PAY: begin
        res_o.byte_kind      = tlv8_pkg::KIND_PAY;
        res_o.record_tag     = tag_eff;
        res_o.payload_byte   = item_i.data_byte;
        res_o.payload_offset = offset_clamped;
        if (!(&offset_eff)) begin
          offset_d = offset_eff + OFFSET_WIDTH'(1);
        end
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          res_o.fragment_done = 1'b1;
          phase_d             = tlv8_pkg::PH_TAG;
        end
      end
      default: begin
        // expect tag, also covers the unused phase code
        res_o.record_tag = item_i.data_byte;
        if (!have_eff || (tag_eff != item_i.data_byte)) begin
          res_o.new_record = 1'b1;
          offset_d         = '0;
        end
        tag_d   = item_i.data_byte;
        have_d  = 1'b1;
        phase_d = tlv8_pkg::PH_LEN;
      end
    endcase

    res_o.phase_after = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tlv8_pkg::PH_TAG;
      tag_q    <= 8'd0;
      have_q   <= 1'b0;
      left_q   <= 8'd0;
      offset_q <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      have_q   <= have_d;
      left_q   <= left_d;
      offset_q <= offset_d;
    end
  end

  // a tag byte always leaves the parser waiting for a length
  a_tag_then_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (res_o.byte_kind == tlv8_pkg::KIND_TAG) |=> phase_q == tlv8_pkg::PH_LEN)
    else $error("tag byte did not move phase to length");

  // a finished fragment always returns to expect tag
  a_done_to_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_o.fragment_done |-> res_o.phase_after == tlv8_pkg::PH_TAG)
    else $error("fragment done without return to tag phase");

  // payload bytes step the record offset until it saturates
  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.fresh_list && (phase_q == tlv8_pkg::PH_PAY) && !(&offset_q)
    |=> offset_q == $past(offset_q) + OFFSET_WIDTH'(1))
    else $error("record offset did not advance on payload byte");

endmodule

[rtl/tlv8_stream_parser_unit.sv]
// path: an input transfer loads the input register, is decoded, then loads the result register
// throughput: one byte per cycle, sustained while the result side keeps taking transfers
// the input register frees itself in the same cycle the result register is loaded
// reset: rst_ni asynchronous active low, clears both valid flags and the parser state
// after reset the parser expects a tag byte with no previous record
// ----------------------------------------------------------------------------
// tlv8_stream_parser_unit
// byte-serial tlv8 stream parser: classifies each byte as tag, length or payload,
// merges fragments of equal tag and tracks the payload offset within a record
// ----------------------------------------------------------------------------
module tlv8_stream_parser_unit #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlv8_in_if.sink     in_i,
  tlv8_out_if.source  out_o
);

  // input register
  logic              in_valid_q;
  tlv8_pkg::item_t   in_q;

  // result register
  logic              out_valid_q;
  tlv8_pkg::result_t res_q;
  tlv8_pkg::result_t res_d;

  // byte moves from the input register into the result register
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  // take a new transfer whenever the input register is empty or draining
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset, only loaded on a transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.data_byte  <= in_i.data_byte;
      in_q.fresh_list <= in_i.fresh_list;
      in_q.chunk_last <= in_i.chunk_last;
    end
  end

  // phase tracking and classification between the two registers
  tlv8_decode #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // result channel driven straight from the result register
  assign out_o.valid          = out_valid_q;
  assign out_o.byte_kind      = res_q.byte_kind;
  assign out_o.record_tag     = res_q.record_tag;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.new_record     = res_q.new_record;
  assign out_o.payload_offset = res_q.payload_offset;
  assign out_o.fragment_done  = res_q.fragment_done;
  assign out_o.phase_after    = res_q.phase_after;
  assign out_o.chunk_end      = res_q.chunk_end;

  // a held byte must not be overwritten while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost a pending byte");

  // every advance leaves a valid result behind
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled after advance");

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule
